// File: rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and widths for the star polygon point containment core.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int SUM_W   = 35;
    localparam int RSQ_W   = 32;
    localparam int ACC_W   = 72;
    localparam int CIDX_W  = 2;
    localparam int STEP_W  = 3;

    localparam logic [CIDX_W-1:0] REG_CENTER_X     = 2'd0;
    localparam logic [CIDX_W-1:0] REG_CENTER_Y     = 2'd1;
    localparam logic [CIDX_W-1:0] REG_INNER_RADIUS = 2'd2;
    localparam logic [CIDX_W-1:0] REG_OUTER_RADIUS = 2'd3;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] DEC_INNER    = 2'd0;
    localparam logic [1:0] DEC_OUTER    = 2'd1;
    localparam logic [1:0] DEC_TRIANGLE = 2'd2;
    localparam logic [1:0] DEC_NO_EDGE  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RADIUS,
        ST_COMPARE,
        ST_WALK,
        ST_TRI_DIFF,
        ST_TRI_PROD,
        ST_TRI_SUM,
        ST_MUL_LOAD,
        ST_MUL_RUN,
        ST_FINAL
    } state_t;

endpackage

// File: rtl/star_polygon_point_containment_core.sv
// ----------------------------------------------------------------------------
// star_polygon_point_containment_core
// Point-in-contour test of a query point against a stored star polygon.
// ----------------------------------------------------------------------------
// Clear and append words leave the core in idle and busy stays low. A query
// is decided by the radius tests, otherwise it goes through the edge walk,
// which reads one stored point a cycle until an edge qualifies. When the
// edge ending at point k qualifies, the walk stops, followed by the setup
// steps TRI_DIFF, TRI_PROD and TRI_SUM, six products on the shared
// shift-add unit and a final step. The result is on inside_res and
// decided_by for the single cycle in which done is high; it cannot be held
// off, so it must be captured then.
module star_polygon_point_containment_core
    import spc_pkg::*;
#(
    parameter int MAX_POINTS = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CIDX_W-1:0]         cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                operation,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    output logic                      done,
    output logic                      inside_res,
    output logic [1:0]                decided_by
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    state_t state_reg;
    state_t state_next;

    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic        [COORD_W-1:0] inner_radius_reg;
    logic        [COORD_W-1:0] outer_radius_reg;

    logic [CW-1:0] count_reg;
    logic          accept;
    logic          app_we;

    logic [2*COORD_W-1:0] mem [MAX_POINTS];
    logic [2*COORD_W-1:0] rdata_reg;

    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;
    logic signed [DIFF_W-1:0]  qx_reg;
    logic signed [DIFF_W-1:0]  qy_reg;
    logic signed [PROD_W-1:0]  qxx_reg;
    logic signed [PROD_W-1:0]  qyy_reg;
    logic        [RSQ_W-1:0]   ir2_reg;
    logic        [RSQ_W-1:0]   or2_reg;
    logic        [SUM_W-1:0]   d2;

    logic [CW-1:0]             issue_reg;
    logic                      issue_en;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;
    logic signed [COORD_W-1:0] bx2_reg;
    logic signed [COORD_W-1:0] by2_reg;
    logic signed [DIFF_W-1:0]  dx2_reg;
    logic signed [DIFF_W-1:0]  dy2_reg;
    logic signed [COORD_W-1:0] bx3_reg;
    logic signed [COORD_W-1:0] by3_reg;
    logic signed [PROD_W-1:0]  pxp3_reg;
    logic signed [PROD_W-1:0]  pyp3_reg;
    logic signed [SUM_W-1:0]   dot;
    logic                      dot_neg;
    logic                      dot_pos;
    logic                      hit;
    logic                      walk_end;
    logic                      have_prev_reg;
    logic                      prev_neg_reg;
    logic                      prev_pos_reg;
    logic signed [COORD_W-1:0] ax_reg;
    logic signed [COORD_W-1:0] ay_reg;
    logic signed [COORD_W-1:0] hx_reg;
    logic signed [COORD_W-1:0] hy_reg;

    logic signed [DIFF_W-1:0] ex_reg;
    logic signed [DIFF_W-1:0] ey_reg;
    logic signed [DIFF_W-1:0] fx_reg;
    logic signed [DIFF_W-1:0] fy_reg;
    logic signed [DIFF_W-1:0] gx_reg;
    logic signed [DIFF_W-1:0] gy_reg;
    logic signed [PROD_W-1:0] p_exex_reg;
    logic signed [PROD_W-1:0] p_eyey_reg;
    logic signed [PROD_W-1:0] p_fxfx_reg;
    logic signed [PROD_W-1:0] p_fyfy_reg;
    logic signed [PROD_W-1:0] p_exfx_reg;
    logic signed [PROD_W-1:0] p_eyfy_reg;
    logic signed [PROD_W-1:0] p_fxgx_reg;
    logic signed [PROD_W-1:0] p_fygy_reg;
    logic signed [PROD_W-1:0] p_exgx_reg;
    logic signed [PROD_W-1:0] p_eygy_reg;
    logic signed [SUM_W-1:0]  ff_reg;
    logic signed [SUM_W-1:0]  ee_reg;
    logic signed [SUM_W-1:0]  ef_reg;
    logic signed [SUM_W-1:0]  gf_reg;
    logic signed [SUM_W-1:0]  ge_reg;

    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic                    mac_start;
    logic                    mac_busy;
    logic signed [SUM_W-1:0] mac_a;
    logic signed [SUM_W-1:0] mac_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic signed [ACC_W-1:0] den_reg;
    logic signed [ACC_W-1:0] nu_reg;
    logic signed [ACC_W-1:0] nv_reg;
    logic signed [ACC_W-1:0] tsum;
    logic                    tri_in;

    logic       done_reg;
    logic       done_next;
    logic       inside_reg;
    logic       inside_next;
    logic [1:0] dec_reg;
    logic [1:0] dec_next;

    assign accept = start && (state_reg == ST_IDLE);
    assign app_we = accept && (operation == OP_APPEND) && (count_reg != CW'(MAX_POINTS));

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            inner_radius_reg <= '0;
            outer_radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X:     center_x_reg     <= cfg_data;
                REG_CENTER_Y:     center_y_reg     <= cfg_data;
                REG_INNER_RADIUS: inner_radius_reg <= cfg_data;
                REG_OUTER_RADIUS: outer_radius_reg <= cfg_data;
                default:          center_x_reg     <= center_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept && (operation == OP_CLEAR))
        begin
            count_reg <= '0;
        end
        else if (app_we)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // point store
    always_ff @(posedge clk)
    begin
        if (app_we)
        begin
            mem[count_reg[AW-1:0]] <= {coord_x, coord_y};
        end
        if (issue_en)
        begin
            rdata_reg <= mem[issue_reg[AW-1:0]];
        end
    end

    // radius tests
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
            qx_reg <= DIFF_W'(coord_x) - DIFF_W'(center_x_reg);
            qy_reg <= DIFF_W'(coord_y) - DIFF_W'(center_y_reg);
        end
        if (state_reg == ST_RADIUS)
        begin
            qxx_reg <= qx_reg * qx_reg;
            qyy_reg <= qy_reg * qy_reg;
            ir2_reg <= inner_radius_reg * inner_radius_reg;
            or2_reg <= outer_radius_reg * outer_radius_reg;
        end
    end

    assign d2 = {1'b0, qxx_reg} + {1'b0, qyy_reg};

    // edge walk
    assign issue_en = (state_reg == ST_WALK) && (issue_reg != count_reg) && !hit;
    assign dot      = SUM_W'(pxp3_reg) + SUM_W'(pyp3_reg);
    assign dot_neg  = dot[SUM_W-1];
    assign dot_pos  = !dot[SUM_W-1] && (dot != '0);
    assign hit      = (state_reg == ST_WALK) && v3_reg && have_prev_reg &&
                      ((prev_neg_reg && dot_pos) || (prev_pos_reg && dot_neg));
    assign walk_end = (issue_reg == count_reg) && !v1_reg && !v2_reg && !v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            have_prev_reg <= 1'b0;
            issue_reg     <= '0;
        end
        else
        begin
            v1_reg <= issue_en;
            v2_reg <= v1_reg && (state_reg == ST_WALK);
            v3_reg <= v2_reg && (state_reg == ST_WALK);
            if (state_reg == ST_COMPARE)
            begin
                issue_reg     <= '0;
                have_prev_reg <= 1'b0;
            end
            else
            begin
                if (issue_en)
                begin
                    issue_reg <= issue_reg + CW'(1);
                end
                if ((state_reg == ST_WALK) && v3_reg && !hit)
                begin
                    have_prev_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bx2_reg  <= rdata_reg[2*COORD_W-1:COORD_W];
        by2_reg  <= rdata_reg[COORD_W-1:0];
        dx2_reg  <= DIFF_W'($signed(rdata_reg[2*COORD_W-1:COORD_W])) - DIFF_W'(center_x_reg);
        dy2_reg  <= DIFF_W'($signed(rdata_reg[COORD_W-1:0])) - DIFF_W'(center_y_reg);
        bx3_reg  <= bx2_reg;
        by3_reg  <= by2_reg;
        pxp3_reg <= qx_reg * dx2_reg;
        pyp3_reg <= qy_reg * dy2_reg;
        if ((state_reg == ST_WALK) && v3_reg)
        begin
            if (hit)
            begin
                hx_reg <= bx3_reg;
                hy_reg <= by3_reg;
            end
            else
            begin
                ax_reg       <= bx3_reg;
                ay_reg       <= by3_reg;
                prev_neg_reg <= dot_neg;
                prev_pos_reg <= dot_pos;
            end
        end
    end

    // triangle test setup
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TRI_DIFF)
        begin
            ex_reg <= DIFF_W'(hx_reg) - DIFF_W'(ax_reg);
            ey_reg <= DIFF_W'(hy_reg) - DIFF_W'(ay_reg);
            fx_reg <= DIFF_W'(center_x_reg) - DIFF_W'(ax_reg);
            fy_reg <= DIFF_W'(center_y_reg) - DIFF_W'(ay_reg);
            gx_reg <= DIFF_W'(px_reg) - DIFF_W'(ax_reg);
            gy_reg <= DIFF_W'(py_reg) - DIFF_W'(ay_reg);
        end
        if (state_reg == ST_TRI_PROD)
        begin
            p_exex_reg <= ex_reg * ex_reg;
            p_eyey_reg <= ey_reg * ey_reg;
            p_fxfx_reg <= fx_reg * fx_reg;
            p_fyfy_reg <= fy_reg * fy_reg;
            p_exfx_reg <= ex_reg * fx_reg;
            p_eyfy_reg <= ey_reg * fy_reg;
            p_fxgx_reg <= fx_reg * gx_reg;
            p_fygy_reg <= fy_reg * gy_reg;
            p_exgx_reg <= ex_reg * gx_reg;
            p_eygy_reg <= ey_reg * gy_reg;
        end
        if (state_reg == ST_TRI_SUM)
        begin
            ff_reg <= SUM_W'(p_fxfx_reg) + SUM_W'(p_fyfy_reg);
            ee_reg <= SUM_W'(p_exex_reg) + SUM_W'(p_eyey_reg);
            ef_reg <= SUM_W'(p_exfx_reg) + SUM_W'(p_eyfy_reg);
            gf_reg <= SUM_W'(p_fxgx_reg) + SUM_W'(p_fygy_reg);
            ge_reg <= SUM_W'(p_exgx_reg) + SUM_W'(p_eygy_reg);
        end
        if ((state_reg == ST_MUL_RUN) && !mac_busy)
        begin
            case (step_reg)
                3'd1:    den_reg <= mac_acc;
                3'd3:    nu_reg  <= mac_acc;
                3'd5:    nv_reg  <= mac_acc;
                default: den_reg <= den_reg;
            endcase
        end
    end

    // den = ff*ee - ef*ef, nu = ee*gf - ef*ge, nv = ff*ge - ef*gf
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                mac_a = ff_reg;
                mac_b = ee_reg;
            end
            3'd1:
            begin
                mac_a = ef_reg;
                mac_b = ef_reg;
            end
            3'd2:
            begin
                mac_a = ee_reg;
                mac_b = gf_reg;
            end
            3'd3:
            begin
                mac_a = ef_reg;
                mac_b = ge_reg;
            end
            3'd4:
            begin
                mac_a = ff_reg;
                mac_b = ge_reg;
            end
            default:
            begin
                mac_a = ef_reg;
                mac_b = gf_reg;
            end
        endcase
    end

    assign mac_start = (state_reg == ST_MUL_LOAD);

    spc_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .clr   (!step_reg[0]),
        .sub   (step_reg[0]),
        .a     (mac_a),
        .b     (mac_b),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    assign tsum   = nu_reg + nv_reg - den_reg;
    assign tri_in = (den_reg == '0) ? 1'b0 :
                    !den_reg[ACC_W-1] ?
                        (!nu_reg[ACC_W-1] && (nu_reg != '0) &&
                         !nv_reg[ACC_W-1] && (nv_reg != '0) && tsum[ACC_W-1]) :
                        (nu_reg[ACC_W-1] && nv_reg[ACC_W-1] &&
                         !tsum[ACC_W-1] && (tsum != '0));

    // control
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        inside_next = inside_reg;
        dec_next    = dec_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_QUERY))
                begin
                    state_next = ST_RADIUS;
                end
            end
            ST_RADIUS:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (d2 < SUM_W'(ir2_reg))
                begin
                    done_next   = 1'b1;
                    inside_next = 1'b1;
                    dec_next    = DEC_INNER;
                    state_next  = ST_IDLE;
                end
                else if (d2 > SUM_W'(or2_reg))
                begin
                    done_next   = 1'b1;
                    inside_next = 1'b0;
                    dec_next    = DEC_OUTER;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    state_next = ST_TRI_DIFF;
                end
                else if (walk_end)
                begin
                    done_next   = 1'b1;
                    inside_next = 1'b0;
                    dec_next    = DEC_NO_EDGE;
                    state_next  = ST_IDLE;
                end
            end
            ST_TRI_DIFF:
            begin
                state_next = ST_TRI_PROD;
            end
            ST_TRI_PROD:
            begin
                state_next = ST_TRI_SUM;
            end
            ST_TRI_SUM:
            begin
                step_next  = '0;
                state_next = ST_MUL_LOAD;
            end
            ST_MUL_LOAD:
            begin
                state_next = ST_MUL_RUN;
            end
            ST_MUL_RUN:
            begin
                if (!mac_busy)
                begin
                    if (step_reg == 3'd5)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        step_next  = step_reg + 3'd1;
                        state_next = ST_MUL_LOAD;
                    end
                end
            end
            ST_FINAL:
            begin
                done_next   = 1'b1;
                inside_next = tri_in;
                dec_next    = DEC_TRIANGLE;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
        dec_reg    <= dec_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign inside_res = inside_reg;
    assign decided_by = dec_reg;

endmodule

// File: rtl/spc_mac.sv
// ----------------------------------------------------------------------------
// spc_mac
// Shift-add multiply-accumulate: acc +/-= a * b, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module spc_mac
    import spc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    clr,
    input  logic                    sub,
    input  logic signed [SUM_W-1:0] a,
    input  logic signed [SUM_W-1:0] b,
    output logic                    busy,
    output logic signed [ACC_W-1:0] acc
);

    logic                    run_reg;
    logic                    run_next;
    logic signed [ACC_W-1:0] mcand_reg;
    logic signed [ACC_W-1:0] mcand_next;
    logic        [SUM_W-1:0] mplier_reg;
    logic        [SUM_W-1:0] mplier_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] a_ext;
    logic                    neg;

    always_comb
    begin
        a_ext       = ACC_W'(a);
        neg         = b[SUM_W-1] ^ sub;
        run_next    = run_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            run_next    = 1'b1;
            mcand_next  = neg ? -a_ext : a_ext;
            mplier_next = b[SUM_W-1] ? -b : b;
            if (clr)
            begin
                acc_next = '0;
            end
        end
        else if (run_reg)
        begin
            if (mplier_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign busy = run_reg;
    assign acc  = acc_reg;

endmodule
